FILE: hw/rtl/rtpr_pkg.sv
// Shared types, register codes and constants of the point residual unit.
package rtpr_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 31;
	localparam int SHIFT_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int RES_WIDTH = 32;
	localparam int MAT_WIDTH = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam longint CordicGain = 64'd652032874;
	localparam longint OneQ30 = 64'd1073741824;
	localparam longint PiQ30 = 64'd3373259426;
	localparam longint HalfPiQ30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ANGLE_X,
		REG_ANGLE_Y,
		REG_ANGLE_Z,
		REG_SHIFT_X,
		REG_SHIFT_Y,
		REG_SHIFT_Z
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BLD_LOAD,
		BLD_ROT,
		BLD_STORE,
		BLD_MUL,
		BLD_DONE
	} build_st_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] src_x;
		logic signed [COORD_WIDTH-1:0] src_y;
		logic signed [COORD_WIDTH-1:0] src_z;
		logic signed [COORD_WIDTH-1:0] tgt_x;
		logic signed [COORD_WIDTH-1:0] tgt_y;
		logic signed [COORD_WIDTH-1:0] tgt_z;
		logic last_point;
	} point_t;

	typedef struct packed {
		logic [RES_WIDTH-1:0] residual;
		logic last_out;
	} result_t;

	typedef struct packed {
		logic [8:0][MAT_WIDTH-1:0] m;
		logic [2:0][SHIFT_WIDTH-1:0] shift;
	} xform_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000007;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/rigid_transform_point_residual_unit.sv
// Top level of the rigid transform point residual unit.
// Takes one point pair a cycle while full is low and returns, in order, the
// distance from the target to the rotated and translated source; one result
// leaves per cycle while pop is held and empty is low. After reset and after
// every angle write, full stays high while a single iterative CORDIC unit (30
// steps per angle, three angles) and one shared multiplier rebuild the
// rotation matrix. Sustained rate is one beat per cycle while the output
// queue is not full, set by the fully pipelined back end (six arithmetic
// stages and one square root stage per result bit).
module rigid_transform_point_residual_unit #(
	parameter int MID_DEPTH = rtpr_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = rtpr_pkg::OUT_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rtpr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [rtpr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  rtpr_pkg::point_t                     point,
	output logic                                 empty,
	input  logic                                 pop,
	output rtpr_pkg::result_t                    result
);
	import rtpr_pkg::*;

	logic mq_wr, mq_rd, mq_full, mq_empty, mat_ready;
	point_t mq_data;
	xform_t xf;
	logic of_wr, of_full;
	result_t of_data;

	rtpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.q_full    (mq_full),
		.full      (full),
		.q_wr      (mq_wr),
		.mat_ready (mat_ready),
		.xf        (xf)
	);

	rtpr_fifo #(.WIDTH($bits(point_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mq_wr),
		.wdata  (point),
		.rd     (mq_rd),
		.rdata  (mq_data),
		.full   (mq_full),
		.empty  (mq_empty)
	);

	rtpr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.xf      (xf),
		.q_empty (mq_empty),
		.q_data  (mq_data),
		.q_rd    (mq_rd),
		.of_full (of_full),
		.of_wr   (of_wr),
		.of_data (of_data)
	);

	rtpr_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (of_wr),
		.wdata  (of_data),
		.rd     (pop),
		.rdata  (result),
		.full   (of_full),
		.empty  (empty)
	);

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mq_wr |-> !mq_full) else $error("mid queue overrun");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		of_wr |-> !of_full) else $error("output queue overrun");

	a_beat_needs_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		mq_wr |-> mat_ready) else $error("beat taken before matrix built");

	a_angle_write_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
		cfg_index == REG_ANGLE_Z) |=> full && !mat_ready)
		else $error("angle write did not start rebuild");
endmodule

FILE: hw/rtl/rtpr_fifo.sv
// Small first-in first-out queue with registered storage.
module rtpr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr, do_rd;

	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: hw/rtl/rtpr_front.sv
// Front end: configuration registers, rotation matrix builder and beat intake.
module rtpr_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rtpr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [rtpr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                 push,
	input  logic                                 q_full,
	output logic                                 full,
	output logic                                 q_wr,
	output logic                                 mat_ready,
	output rtpr_pkg::xform_t                     xf
);
	import rtpr_pkg::*;

	localparam int XW = 34;
	localparam int ZW = 36;
	localparam logic signed [ZW-1:0] Z_PI = ZW'(PiQ30);
	localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(HalfPiQ30);
	localparam logic signed [XW-1:0] X_GAIN = XW'(CordicGain);
	localparam logic signed [XW-1:0] X_ONE = XW'(OneQ30);
	localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
	localparam logic [3:0] LAST_STEP = 4'd13;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [ANGLE_WIDTH-1:0] angle_q [3];
	logic [SHIFT_WIDTH-1:0] shift_q [3];
	build_st_t st_q, st_d;
	logic ang_wr;
	logic [1:0] idx_q;
	logic [4:0] iter_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic neg_q;
	logic signed [31:0] cos_q [3];
	logic signed [31:0] sin_q [3];
	logic [3:0] mstep_q, ptag_q;
	logic pvld_q;
	logic signed [63:0] prod_q;
	logic signed [32:0] acc_q;
	logic signed [31:0] sxsy_q, cxsy_q;
	logic signed [31:0] mat_q [9];

	logic signed [ZW-1:0] z0, z_ld;
	logic neg_ld;
	logic signed [XW-1:0] xs, ys, x_cl, y_cl;
	logic signed [ZW-1:0] at_w;
	logic signed [31:0] op_a, op_b;
	logic signed [63:0] rsum;
	logic signed [32:0] r_w;

	// configuration
	always_comb begin
		ang_wr = 1'b0;
		if (cfg_we) begin
			case (cfg_index) inside
				REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z: ang_wr = 1'b1;
				default: ang_wr = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				angle_q[i] <= '0;
				shift_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_X: angle_q[0] <= cfg_data[ANGLE_WIDTH-1:0];
				REG_ANGLE_Y: angle_q[1] <= cfg_data[ANGLE_WIDTH-1:0];
				REG_ANGLE_Z: angle_q[2] <= cfg_data[ANGLE_WIDTH-1:0];
				REG_SHIFT_X: shift_q[0] <= cfg_data[SHIFT_WIDTH-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[SHIFT_WIDTH-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[SHIFT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// builder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BLD_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BLD_LOAD: st_d = BLD_ROT;
			BLD_ROT: if (iter_q == LAST_ITER) st_d = BLD_STORE;
			BLD_STORE: st_d = (idx_q == 2'd2) ? BLD_MUL : BLD_LOAD;
			BLD_MUL: if (pvld_q && ptag_q == LAST_STEP) st_d = BLD_DONE;
			BLD_DONE: st_d = BLD_DONE;
			default: st_d = BLD_LOAD;
		endcase
		if (ang_wr) begin
			st_d = BLD_LOAD;
		end
	end

	// CORDIC datapath
	always_comb begin
		z0 = ZW'(angle_q[idx_q]) <<< 2;
		z_ld = z0;
		neg_ld = 1'b0;
		if (z0 > Z_HALF_PI) begin
			z_ld = z0 - Z_PI;
			neg_ld = 1'b1;
		end else if (z0 < -Z_HALF_PI) begin
			z_ld = z0 + Z_PI;
			neg_ld = 1'b1;
		end
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at_w = ZW'(atan_q30(iter_q));
		x_cl = (x_q > X_ONE) ? X_ONE : ((x_q < -X_ONE) ? -X_ONE : x_q);
		y_cl = (y_q > X_ONE) ? X_ONE : ((y_q < -X_ONE) ? -X_ONE : y_q);
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BLD_LOAD: begin
				x_q <= X_GAIN;
				y_q <= '0;
				z_q <= z_ld;
				neg_q <= neg_ld;
			end
			BLD_ROT: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at_w;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at_w;
				end
			end
			BLD_STORE: begin
				cos_q[idx_q] <= neg_q ? 32'(-x_cl) : 32'(x_cl);
				sin_q[idx_q] <= neg_q ? 32'(-y_cl) : 32'(y_cl);
			end
			default: ;
		endcase
	end

	// product sequencer: cos/sin index 0 = x, 1 = y, 2 = z
	always_comb begin
		case (mstep_q)
			4'd0: begin op_a = sin_q[0]; op_b = sin_q[1]; end
			4'd1: begin op_a = cos_q[0]; op_b = sin_q[1]; end
			4'd2: begin op_a = cos_q[1]; op_b = cos_q[2]; end
			4'd3: begin op_a = cos_q[1]; op_b = sin_q[2]; end
			4'd4: begin op_a = sin_q[0]; op_b = cos_q[1]; end
			4'd5: begin op_a = cos_q[0]; op_b = cos_q[1]; end
			4'd6: begin op_a = cos_q[0]; op_b = sin_q[2]; end
			4'd7: begin op_a = sxsy_q; op_b = cos_q[2]; end
			4'd8: begin op_a = cos_q[0]; op_b = cos_q[2]; end
			4'd9: begin op_a = sxsy_q; op_b = sin_q[2]; end
			4'd10: begin op_a = sin_q[0]; op_b = sin_q[2]; end
			4'd11: begin op_a = cxsy_q; op_b = cos_q[2]; end
			4'd12: begin op_a = sin_q[0]; op_b = cos_q[2]; end
			4'd13: begin op_a = cxsy_q; op_b = sin_q[2]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		rsum = prod_q + 64'sd536870912;
		r_w = rsum[62:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			iter_q <= '0;
			mstep_q <= '0;
			ptag_q <= '0;
			pvld_q <= 1'b0;
			prod_q <= '0;
			acc_q <= '0;
			sxsy_q <= '0;
			cxsy_q <= '0;
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i % 4 == 0) ? 32'(OneQ30) : '0;
			end
		end else if (ang_wr) begin
			idx_q <= '0;
			pvld_q <= 1'b0;
		end else begin
			case (st_q)
				BLD_LOAD: iter_q <= '0;
				BLD_ROT: iter_q <= iter_q + 1'b1;
				BLD_STORE: begin
					if (idx_q != 2'd2) begin
						idx_q <= idx_q + 1'b1;
					end
					mstep_q <= '0;
					pvld_q <= 1'b0;
				end
				BLD_MUL: begin
					if (mstep_q <= LAST_STEP) begin
						prod_q <= 64'(op_a) * 64'(op_b);
						ptag_q <= mstep_q;
						pvld_q <= 1'b1;
						mstep_q <= mstep_q + 1'b1;
					end else begin
						pvld_q <= 1'b0;
					end
					if (pvld_q) begin
						case (ptag_q)
							4'd0: sxsy_q <= r_w[31:0];
							4'd1: cxsy_q <= r_w[31:0];
							4'd2: mat_q[0] <= sat32(34'(r_w));
							4'd3: mat_q[1] <= sat32(-34'(r_w));
							4'd4: mat_q[5] <= sat32(-34'(r_w));
							4'd5: mat_q[8] <= sat32(34'(r_w));
							4'd6, 4'd8, 4'd10, 4'd12: acc_q <= r_w;
							4'd7: mat_q[3] <= sat32(34'(acc_q) + 34'(r_w));
							4'd9: mat_q[4] <= sat32(34'(acc_q) - 34'(r_w));
							4'd11: mat_q[6] <= sat32(34'(acc_q) - 34'(r_w));
							4'd13: begin
								mat_q[7] <= sat32(34'(acc_q) + 34'(r_w));
								mat_q[2] <= sin_q[1];
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	assign mat_ready = (st_q == BLD_DONE);
	assign full = !mat_ready || q_full;
	assign q_wr = push && !full;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			xf.m[i] = mat_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			xf.shift[i] = shift_q[i];
		end
	end
endmodule

FILE: hw/rtl/rtpr_back.sv
// Back end: transform, difference, squared sum and square root pipeline.
module rtpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rtpr_pkg::xform_t   xf,
	input  logic               q_empty,
	input  rtpr_pkg::point_t   q_data,
	output logic               q_rd,
	input  logic               of_full,
	output logic               of_wr,
	output rtpr_pkg::result_t  of_data
);
	import rtpr_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int HIW = (CW > 16) ? CW - 16 : 1;
	localparam int PHW = HIW + MAT_WIDTH;
	localparam int PLW = 17 + MAT_WIDTH;
	localparam int PFW = PHW + 17;
	localparam int PW = PFW - 30;
	localparam int SW = (CW + 8 > 34) ? CW + 8 : 34;
	localparam int NR = RES_WIDTH;
	localparam logic signed [PFW-1:0] HALF_LSB = PFW'(1) << 29;

	logic adv;
	logic signed [CW-1:0] src [3];
	logic signed [CW-1:0] tgt [3];
	logic signed [HIW-1:0] hi [3];
	logic [15:0] lo [3];
	logic signed [MAT_WIDTH-1:0] m [9];
	logic signed [SHIFT_WIDTH-1:0] sh [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [PHW-1:0] ph_s1 [9];
	logic signed [PLW-1:0] pl_s1 [9];
	logic signed [PW-1:0] p_s2 [9];
	logic signed [SW-1:0] rs_s3 [3];
	logic signed [CW-1:0] tgt_s1 [3], tgt_s2 [3], tgt_s3 [3];
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [31:0] mag_s4 [3];
	logic sat_s4, sat_s5, sat_s6;
	logic [63:0] sq_s5 [3];
	logic [63:0] n_s6;

	logic vld_s7 [NR];
	logic [63:0] rem_s7 [NR];
	logic [NR-1:0] root_s7 [NR];
	logic sat_s7 [NR];
	logic last_s7 [NR];

	logic signed [SW-1:0] d_w [3];
	logic [SW-1:0] mag_w [3];
	logic [65:0] sum_w;

	assign adv = !of_full;
	assign q_rd = adv && !q_empty;

	always_comb begin
		src[0] = q_data.src_x;
		src[1] = q_data.src_y;
		src[2] = q_data.src_z;
		tgt[0] = q_data.tgt_x;
		tgt[1] = q_data.tgt_y;
		tgt[2] = q_data.tgt_z;
		for (int c = 0; c < 3; c++) begin
			hi[c] = HIW'(src[c] >>> 16);
			lo[c] = src[c][15:0];
			sh[c] = xf.shift[c];
		end
		for (int k = 0; k < 9; k++) begin
			m[k] = xf.m[k];
		end
		for (int r = 0; r < 3; r++) begin
			d_w[r] = SW'(tgt_s3[r]) - rs_s3[r];
			mag_w[r] = d_w[r][SW-1] ? SW'(-d_w[r]) : SW'(d_w[r]);
		end
		sum_w = 66'(sq_s5[0]) + 66'(sq_s5[1]) + 66'(sq_s5[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				ph_s1[k] <= PHW'(hi[k % 3]) * PHW'(m[k]);
				pl_s1[k] <= PLW'($signed({1'b0, lo[k % 3]})) * PLW'(m[k]);
				p_s2[k] <= PW'(((PFW'(ph_s1[k]) <<< 16) + PFW'(pl_s1[k]) + HALF_LSB) >>> 30);
			end
			for (int r = 0; r < 3; r++) begin
				tgt_s1[r] <= tgt[r];
				tgt_s2[r] <= tgt_s1[r];
				tgt_s3[r] <= tgt_s2[r];
				rs_s3[r] <= SW'(p_s2[3*r]) + SW'(p_s2[3*r+1]) + SW'(p_s2[3*r+2]) + SW'(sh[r]);
				mag_s4[r] <= mag_w[r][31:0];
				sq_s5[r] <= 64'(mag_s4[r]) * 64'(mag_s4[r]);
			end
			last_s1 <= q_data.last_point;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			last_s5 <= last_s4;
			last_s6 <= last_s5;
			sat_s4 <= (|mag_w[0][SW-1:32]) || (|mag_w[1][SW-1:32]) || (|mag_w[2][SW-1:32]);
			sat_s5 <= sat_s4;
			sat_s6 <= sat_s5 || (|sum_w[65:64]);
			n_s6 <= sum_w[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// one root bit per stage, most significant first
	for (genvar j = 0; j < NR; j++) begin : g_sqrt
		localparam int B = NR - 1 - j;
		logic vin, sin_w, lin;
		logic [63:0] rin, trial;
		logic [NR-1:0] qin;

		if (j == 0) begin : g_first
			assign vin = vld_s6;
			assign rin = n_s6;
			assign qin = '0;
			assign sin_w = sat_s6;
			assign lin = last_s6;
		end else begin : g_next
			assign vin = vld_s7[j-1];
			assign rin = rem_s7[j-1];
			assign qin = root_s7[j-1];
			assign sin_w = sat_s7[j-1];
			assign lin = last_s7[j-1];
		end

		assign trial = (64'(qin) << (B + 1)) | (64'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (adv) begin
				sat_s7[j] <= sin_w;
				last_s7[j] <= lin;
				if (rin >= trial) begin
					rem_s7[j] <= rin - trial;
					root_s7[j] <= qin | (NR'(1) << B);
				end else begin
					rem_s7[j] <= rin;
					root_s7[j] <= qin;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s7[j] <= 1'b0;
			end else if (adv) begin
				vld_s7[j] <= vin;
			end
		end
	end

	assign of_wr = adv && vld_s7[NR-1];
	assign of_data.residual = sat_s7[NR-1] ? '1 : root_s7[NR-1];
	assign of_data.last_out = last_s7[NR-1];
endmodule

FILE: tb/tb_rigid_transform_point_residual_unit.sv
// Testbench of the point residual unit: table-driven and random point pairs, checked in order.
`timescale 1ns / 100ps

module tb_rigid_transform_point_residual_unit;
	import rtpr_pkg::*;

	localparam int NUM_REGS = 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES = 10;
	localparam int PER_PHASE = 130;
	localparam longint ANGLE_MAX = 843314856;

	typedef struct {
		point_t pt;
		bit typed;
		logic [RES_WIDTH-1:0] res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	point_t point = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;

	logic [ANGLE_WIDTH-1:0] ang_r[3];
	logic [SHIFT_WIDTH-1:0] shift_r[3];
	longint rot[9];
	bit rot_valid;

	result_t residual_q[$];
	row_t rows[$];
	int errors = 0;
	int cycles = 0;

	rigid_transform_point_residual_unit u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .point(point),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint round_q30(longint a, longint b);
		return (a * b + (OneQ30 >>> 1)) >>> 30;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic sin_cos(input logic [ANGLE_WIDTH-1:0] a, output longint c,
			output longint s);
		longint z, x, y, t;
		bit flip;
		z = longint'($signed(a)) * 4;
		x = CordicGain;
		y = 0;
		flip = 1'b0;
		if (z > HalfPiQ30) begin
			z -= PiQ30;
			flip = 1'b1;
		end else if (z < -HalfPiQ30) begin
			z += PiQ30;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(atan_q30(5'(i)));
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(atan_q30(5'(i)));
			end
			x = t;
		end
		x = clip(x, -OneQ30, OneQ30);
		y = clip(y, -OneQ30, OneQ30);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic build_rotation();
		longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
		longint lo, hi;
		lo = -64'sd2147483648;
		hi = 64'sd2147483647;
		sin_cos(ang_r[0], cx, sx);
		sin_cos(ang_r[1], cy, sy);
		sin_cos(ang_r[2], cz, sz);
		sxsy = round_q30(sx, sy);
		cxsy = round_q30(cx, sy);
		rot[0] = clip(round_q30(cy, cz), lo, hi);
		rot[1] = clip(-round_q30(cy, sz), lo, hi);
		rot[2] = clip(sy, lo, hi);
		rot[3] = clip(round_q30(cx, sz) + round_q30(sxsy, cz), lo, hi);
		rot[4] = clip(round_q30(cx, cz) - round_q30(sxsy, sz), lo, hi);
		rot[5] = clip(-round_q30(sx, cy), lo, hi);
		rot[6] = clip(round_q30(sx, sz) - round_q30(cxsy, cz), lo, hi);
		rot[7] = clip(round_q30(sx, cz) + round_q30(cxsy, sz), lo, hi);
		rot[8] = clip(round_q30(cx, cy), lo, hi);
		rot_valid = 1'b1;
	endtask

	function automatic longint scale_coord(longint a, longint m);
		longint lo, hi, p, plo, r;
		lo = a & 64'hFFFF;
		hi = a >>> 16;
		p = hi * m;
		plo = p & 64'h3FFF;
		r = plo * 65536 + lo * m + (OneQ30 >>> 1);
		return (p >>> 14) + (r >>> 30);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	task automatic predict_residual(input point_t p, output result_t o);
		longint src[3], tgt[3], d;
		longint unsigned sum, sq;
		bit sat;
		if (!rot_valid)
			build_rotation();
		src = '{longint'(p.src_x), longint'(p.src_y), longint'(p.src_z)};
		tgt = '{longint'(p.tgt_x), longint'(p.tgt_y), longint'(p.tgt_z)};
		sum = 0;
		sat = 1'b0;
		for (int r = 0; r < 3; r++) begin
			d = scale_coord(src[0], rot[3*r]) + scale_coord(src[1], rot[3*r+1])
				+ scale_coord(src[2], rot[3*r+2]) + longint'($signed(shift_r[r]));
			d = tgt[r] - d;
			if (d <= -64'sd4294967296 || d >= 64'sd4294967296) begin
				sat = 1'b1;
			end else begin
				if (d < 0)
					d = -d;
				sq = longint'(d) * longint'(d);
				if (sum + sq < sum)
					sat = 1'b1;
				sum += sq;
			end
		end
		o.residual = sat ? 32'hFFFFFFFF : 32'(floor_sqrt(sum));
		o.last_out = p.last_point;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < REG_SHIFT_X) begin
			ang_r[idx] = val[ANGLE_WIDTH-1:0];
			rot_valid = 1'b0;
		end else if (idx < NUM_REGS) begin
			shift_r[idx - REG_SHIFT_X] = val;
		end
	endtask

	task automatic wait_idle();
		wait (residual_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return 0;
		if (k < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_pair(input point_t p, input bit typed,
			input logic [RES_WIDTH-1:0] res, input bit gaps);
		result_t o;
		int g;
		@(negedge clk);
		push = 1'b1;
		point = p;
		do
			@(posedge clk);
		while (full);
		predict_residual(p, o);
		if (typed)
			o.residual = res;
		residual_q.push_back(o);
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			@(negedge clk);
			push = 1'b0;
			point = '0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	function automatic logic [COORD_WIDTH-1:0] rand_coord();
		logic [COORD_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'h80000000;
					1: v = 32'h7FFFFFFF;
					2: v = 32'hFFFFFFFF;
					default: v = '0;
				endcase
			end
			default: v = COORD_WIDTH'($signed(22'($urandom)));
		endcase
		return v;
	endfunction

	function automatic point_t rand_pair();
		point_t p;
		p.src_x = rand_coord();
		p.src_y = rand_coord();
		p.src_z = rand_coord();
		p.tgt_x = rand_coord();
		p.tgt_y = rand_coord();
		p.tgt_z = rand_coord();
		p.last_point = ($urandom_range(0, 7) == 0);
		return p;
	endfunction

	function automatic logic [CFG_DATA_WIDTH-1:0] rand_angle();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return CFG_DATA_WIDTH'($signed(longint'($urandom_range(0, 2 * ANGLE_MAX))
			- ANGLE_MAX));
	endfunction

	task automatic setup_phase(input int ph);
		case (ph)
			1: begin
				for (int i = 0; i < 3; i++)
					write_reg(CFG_INDEX_WIDTH'(i), CFG_DATA_WIDTH'(ANGLE_MAX));
				for (int i = REG_SHIFT_X; i < NUM_REGS; i++)
					write_reg(CFG_INDEX_WIDTH'(i), 32'h7FFFFFFF);
			end
			2: begin
				for (int i = 0; i < 3; i++)
					write_reg(CFG_INDEX_WIDTH'(i), CFG_DATA_WIDTH'(-ANGLE_MAX));
				for (int i = REG_SHIFT_X; i < NUM_REGS; i++)
					write_reg(CFG_INDEX_WIDTH'(i), 32'h80000000);
			end
			3: begin
				for (int i = 0; i < NUM_REGS; i++)
					write_reg(CFG_INDEX_WIDTH'(i), '0);
			end
			4: begin
				for (int i = NUM_REGS; i < (1 << CFG_INDEX_WIDTH); i++)
					write_reg(CFG_INDEX_WIDTH'(i), $urandom);
				write_reg(REG_ANGLE_Y, 32'h80000000 | CFG_DATA_WIDTH'(ANGLE_MAX / 3));
			end
			default: begin
				for (int i = 0; i < 3; i++)
					write_reg(CFG_INDEX_WIDTH'(i), rand_angle());
				for (int i = REG_SHIFT_X; i < NUM_REGS; i++)
					write_reg(CFG_INDEX_WIDTH'(i), $urandom_range(0, 1) ?
						$urandom : CFG_DATA_WIDTH'($signed(24'($urandom))));
			end
		endcase
	endtask

	function automatic point_t mk(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
			logic [31:0] tx, logic [31:0] ty, logic [31:0] tz, logic lp);
		point_t p;
		p = '{src_x: sx, src_y: sy, src_z: sz, tgt_x: tx, tgt_y: ty, tgt_z: tz,
			last_point: lp};
		return p;
	endfunction

	// receiving side: random pop gaps
	initial begin
		int g;
		forever begin
			@(negedge clk);
			g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (g > 0) begin
				pop = 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (residual_q.size() == 0) begin
				$error("unexpected result beat: residual %h", result.residual);
				errors++;
			end else begin
				want = residual_q.pop_front();
				if (result.residual !== want.residual) begin
					$error("residual: expected %h, got %h", want.residual, result.residual);
					errors++;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, result.last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 3; i++) begin
			ang_r[i] = '0;
			shift_r[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			rot[i] = (i % 4 == 0) ? OneQ30 : 0;
		rot_valid = 1'b0;

		// zero source maps to zero, so these distances are exact under reset settings
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, 32'h0});
		rows.push_back('{mk(0, 0, 0, 32'h30000, 32'h40000, 0, 1), 1'b1, 32'h50000});
		rows.push_back('{mk(0, 0, 0, 32'h7FFFFFFF, 0, 0, 0), 1'b1, 32'h7FFFFFFF});
		rows.push_back('{mk(0, 0, 0, 0, 32'h80000000, 0, 1), 1'b1, 32'h80000000});
		rows.push_back('{mk(0, 0, 0, 0, 0, 32'h80000000, 0), 1'b1, 32'h80000000});
		rows.push_back('{mk(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 0), 1'b0, 'x});
		rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1), 1'b0, 'x});
		rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 0), 1'b0, 'x});
		rows.push_back('{mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1), 1'b0, 'x});
		rows.push_back('{mk(32'h10000, 32'h20000, 32'h30000,
			32'h10000, 32'h20000, 32'h30000, 0), 1'b0, 'x});
		rows.push_back('{mk(32'h1, 32'h8000, 32'hFFFF8000, 32'h1, 0, 0, 1), 1'b0, 'x});
		rows.push_back('{mk(32'h55555555, 32'hAAAAAAAA, 32'h12345678,
			32'hAAAAAAAA, 32'h55555555, 32'hEDCBA988, 0), 1'b0, 'x});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_pair(rows[i].pt, rows[i].typed, rows[i].res, 1'b0);
		@(negedge clk);
		push = 1'b0;

		for (int ph = 1; ph <= PHASES; ph++) begin
			wait_idle();
			setup_phase(ph);
			// rows with extreme targets also under large shifts
			if (ph <= 2)
				send_pair(mk(0, 0, 0, 32'h80000000, 32'h80000000, 0, 1), 1'b0, 'x, 1'b0);
			for (int n = 0; n < PER_PHASE; n++)
				send_pair(rand_pair(), 1'b0, 'x, 1'b1);
			@(negedge clk);
			push = 1'b0;
		end

		wait (residual_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && residual_q.size() == 0) begin
			$display("tb: success");
		end else begin
			if (residual_q.size() != 0)
				$error("results missing: %0d", residual_q.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: rigid_transform_point_residual_unit.f
hw/rtl/rtpr_pkg.sv
hw/rtl/rtpr_fifo.sv
hw/rtl/rtpr_front.sv
hw/rtl/rtpr_back.sv
hw/rtl/rigid_transform_point_residual_unit.sv
tb/tb_rigid_transform_point_residual_unit.sv
